// ----- rtl/sacl_pkg.sv -----
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared constants, codes and types of the set-associative LRU write-back
// cache model: geometry, register map, outcome codes and the structs that
// pass between the sequencer, the way scanner and the statistics block.
// ----------------------------------------------------------------------------
package sacl_pkg;

    // Geometry.
    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_BITS    = 64;

    localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS  = 1 << SET_IDX_W;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
    localparam int LINE_W    = SET_IDX_W + WAY_W;
    localparam int NUM_LINES = 1 << LINE_W;
    localparam int TAG_W     = ADDR_BITS;

    // Fixed field widths.
    localparam int RANK_W   = 3;
    localparam logic [RANK_W-1:0] RANK_MAX = '1;
    localparam int CNT_W    = 32;
    localparam int DIRTY_W  = 10;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 4;

    // Register map, as word indexes.
    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_BLOCK_BITS  = 2'd1;
    localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

    // Outcome codes.
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [2:0] set_bits;
        logic [5:0] block_bits;
        logic [3:0] ways_in_use;
    } cfg_t;

    // Metadata of one set.
    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0]             dirty;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } meta_row_t;

    // What the way scan found after walking a set.
    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic             empty;
        logic [WAY_W-1:0] empty_way;
        logic [WAY_W-1:0] vict_way;
        logic [RANK_W-1:0] vict_rank;
    } scan_t;

    // One step of the way scan.
    typedef struct packed {
        logic              en;
        logic              first;
        logic [WAY_W-1:0]  way;
        logic              valid;
        logic [RANK_W-1:0] rank;
    } scan_step_t;

    // Statistics events of one committed access.
    typedef struct packed {
        logic commit;
        logic hit;
        logic evict;
        logic dirty_evict;
        logic dirty_inc;
        logic dirty_dec;
    } stat_evt_t;

    // Running statistics.
    typedef struct packed {
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   misses;
        logic [CNT_W-1:0]   evictions;
        logic [DIRTY_W-1:0] dirty_res;
        logic [CNT_W-1:0]   dirty_evicts;
    } stats_t;

endpackage

// ----- rtl/sacl_if.sv -----
// ----------------------------------------------------------------------------
// sacl_if
// Valid/ready channels of the cache model: the access channel carries one
// access word, the result channel carries one result word.
// ----------------------------------------------------------------------------
interface sacl_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] access_address;

    modport source (output valid, output command, output access_address, input ready);
    modport sink (input valid, input command, input access_address, output ready);
endinterface

interface sacl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic        victim_was_dirty;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
    logic [9:0]  dirty_resident;
    logic [31:0] dirty_evicted_total;

    modport source (
        output valid, output outcome, output victim_was_dirty, output hit_total,
        output miss_total, output eviction_total, output dirty_resident,
        output dirty_evicted_total, input ready
    );
    modport sink (
        input valid, input outcome, input victim_was_dirty, input hit_total,
        input miss_total, input eviction_total, input dirty_resident,
        input dirty_evicted_total, output ready
    );
endinterface

// ----- rtl/sacl_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sacl_cfg_regs
// APB-style register block holding set_bits, block_bits and ways_in_use.
// Writes land in the access phase; reads return the stored value.
// ----------------------------------------------------------------------------
module sacl_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sacl_pkg::PADDR_W-1:0] paddr,
    input  logic [sacl_pkg::DATA_W-1:0]  pwdata,
    output logic [sacl_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output sacl_pkg::cfg_t               cfg
);

    sacl_pkg::cfg_t cfg_reg;
    sacl_pkg::cfg_t cfg_next;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                sacl_pkg::REG_SET_BITS:    cfg_next.set_bits    = pwdata[2:0];
                sacl_pkg::REG_BLOCK_BITS:  cfg_next.block_bits  = pwdata[5:0];
                sacl_pkg::REG_WAYS_IN_USE: cfg_next.ways_in_use = pwdata[3:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_bits    <= 3'd0;
            cfg_reg.block_bits  <= 6'd0;
            cfg_reg.ways_in_use <= 4'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read data mux.
    always_comb
    begin
        case (reg_idx)
            sacl_pkg::REG_SET_BITS:    prdata = {29'd0, cfg_reg.set_bits};
            sacl_pkg::REG_BLOCK_BITS:  prdata = {26'd0, cfg_reg.block_bits};
            sacl_pkg::REG_WAYS_IN_USE: prdata = {28'd0, cfg_reg.ways_in_use};
            default:                   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/sacl_way_scan.sv -----
// ----------------------------------------------------------------------------
// sacl_way_scan
// Shared way scanner: one tag compare and one rank compare per cycle. It
// walks the ways of a set and keeps the first hit, the first invalid way and
// the lowest-numbered way of greatest rank.
// ----------------------------------------------------------------------------
module sacl_way_scan (
    input  logic                       clk,
    input  sacl_pkg::scan_step_t       step,
    input  logic [sacl_pkg::TAG_W-1:0] line_tag,
    input  logic [sacl_pkg::TAG_W-1:0] ref_tag,
    output sacl_pkg::scan_t            res
);

    sacl_pkg::scan_t res_reg;
    sacl_pkg::scan_t res_next;
    logic            match;

    // The one tag comparator of the block.
    assign match = step.valid && (line_tag == ref_tag);

    // Fold the current way into the running result.
    always_comb
    begin
        res_next = res_reg;
        if (step.en)
        begin
            if (step.first)
            begin
                res_next.hit       = match;
                res_next.hit_way   = step.way;
                res_next.empty     = !step.valid;
                res_next.empty_way = step.way;
                res_next.vict_way  = step.way;
                res_next.vict_rank = step.rank;
            end
            else
            begin
                if (!res_reg.hit && match)
                begin
                    res_next.hit     = 1'b1;
                    res_next.hit_way = step.way;
                end
                if (!res_reg.empty && !step.valid)
                begin
                    res_next.empty     = 1'b1;
                    res_next.empty_way = step.way;
                end
                if (step.rank > res_reg.vict_rank)
                begin
                    res_next.vict_way  = step.way;
                    res_next.vict_rank = step.rank;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ----- rtl/sacl_stats.sv -----
// ----------------------------------------------------------------------------
// sacl_stats
// Running statistics: saturating hit, miss, eviction and dirty-eviction
// counts, and the number of dirty lines held.
// ----------------------------------------------------------------------------
module sacl_stats (
    input  logic                clk,
    input  logic                rst_n,
    input  sacl_pkg::stat_evt_t evt,
    output sacl_pkg::stats_t    stats_next
);

    sacl_pkg::stats_t stats_reg;

    function automatic logic [sacl_pkg::CNT_W-1:0] sat_inc(
        input logic [sacl_pkg::CNT_W-1:0] v,
        input logic                       en
    );
        logic [sacl_pkg::CNT_W-1:0] r;
        r = v;
        if (en && (v != '1))
        begin
            r = v + 1'b1;
        end
        return r;
    endfunction

    // Counts after the access being committed.
    always_comb
    begin
        stats_next              = stats_reg;
        stats_next.hits         = sat_inc(stats_reg.hits, evt.hit);
        stats_next.misses       = sat_inc(stats_reg.misses, !evt.hit);
        stats_next.evictions    = sat_inc(stats_reg.evictions, evt.evict);
        stats_next.dirty_evicts = sat_inc(stats_reg.dirty_evicts, evt.dirty_evict);
        if (evt.dirty_inc)
        begin
            stats_next.dirty_res = stats_reg.dirty_res + 1'b1;
        end
        else if (evt.dirty_dec)
        begin
            stats_next.dirty_res = stats_reg.dirty_res - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_reg <= '0;
        end
        else if (evt.commit)
        begin
            stats_reg <= stats_next;
        end
    end

endmodule

// ----- rtl/set_assoc_cache_lru_writeback_sim.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_writeback_sim
// Set-associative write-back cache model with true LRU replacement and
// running statistics.
// ----------------------------------------------------------------------------
// An access runs from acceptance to its result word through the states:
// the address is split in the cycle the access is accepted, then ST_LOOKUP
// reads the set's metadata row and first tag, ST_SCAN runs the single tag
// comparator over each way in use in turn, and ST_UPDATE writes back the row,
// the tag and the counters. The block takes one access at a time and returns
// to idle between accesses. The result sits in an output register, so the
// next access can be accepted while a result is still waiting; that access
// then holds in its write-back state until the waiting word is taken.
// Metadata rows carry a flip-flop each that reset clears, so there is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_writeback_sim (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sacl_pkg::PADDR_W-1:0] paddr,
    input  logic [sacl_pkg::DATA_W-1:0]  pwdata,
    output logic [sacl_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    sacl_in_if.sink                      req,
    sacl_out_if.source                   rsp
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    sacl_pkg::cfg_t cfg;

    // Access context.
    logic                              store_reg;
    logic [sacl_pkg::TAG_W-1:0]        tag_reg;
    logic [sacl_pkg::SET_IDX_W-1:0]    set_reg;
    logic [sacl_pkg::WCNT_W-1:0]       ways_reg;
    logic [sacl_pkg::WAY_W-1:0]        rd_way_reg;
    logic [sacl_pkg::WAY_W-1:0]        scan_way_reg;

    // Address split.
    logic [sacl_pkg::ADDR_BITS-1:0]    addr_m;
    logic [3:0]                        s_eff;
    logic [6:0]                        tag_sh;
    logic [sacl_pkg::ADDR_BITS-1:0]    set_shifted;
    logic [sacl_pkg::TAG_W-1:0]        tag_calc;
    logic [sacl_pkg::SET_IDX_W-1:0]    set_calc;
    logic [4:0]                        ways_raw;
    logic [4:0]                        ways_clamp;

    // Storage.
    logic [sacl_pkg::TAG_W-1:0]        tag_mem [sacl_pkg::NUM_LINES];
    sacl_pkg::meta_row_t               meta_mem [sacl_pkg::NUM_SETS];
    logic [sacl_pkg::NUM_SETS-1:0]     row_init_reg;
    logic [sacl_pkg::TAG_W-1:0]        tag_q;
    sacl_pkg::meta_row_t               meta_q;
    logic                              init_q;
    sacl_pkg::meta_row_t               meta;
    sacl_pkg::meta_row_t               meta_new;

    // Scan and decision.
    sacl_pkg::scan_step_t              step;
    sacl_pkg::scan_t                   scan;
    logic                              last_way;
    logic [sacl_pkg::WAY_W-1:0]        w;
    logic                              old_dirty;
    logic                              new_dirty;
    logic [3:0]                        limit;
    logic                              is_evict;
    logic                              commit;
    sacl_pkg::stat_evt_t               evt;
    sacl_pkg::stats_t                  stats_next;

    // Result register.
    logic                              out_valid_reg;
    logic [1:0]                        outcome_reg;
    logic                              vdirty_reg;
    sacl_pkg::stats_t                  stats_out_reg;

    sacl_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Split the incoming address into tag and set under the current config.
    assign addr_m      = req.access_address[sacl_pkg::ADDR_BITS-1:0];
    assign s_eff       = ({1'b0, cfg.set_bits} > 4'(sacl_pkg::MAX_SET_BITS))
                         ? 4'(sacl_pkg::MAX_SET_BITS) : {1'b0, cfg.set_bits};
    assign tag_sh      = 7'(s_eff) + 7'(cfg.block_bits);
    assign tag_calc    = (tag_sh >= 7'(sacl_pkg::ADDR_BITS)) ? '0 : (addr_m >> tag_sh);
    assign set_shifted = addr_m >> cfg.block_bits;

    always_comb
    begin
        for (int i = 0; i < sacl_pkg::SET_IDX_W; i++)
        begin
            set_calc[i] = set_shifted[i] && (4'(i) < s_eff);
        end
    end

    // Clamp the associativity to 1..MAX_WAYS.
    assign ways_raw   = {1'b0, cfg.ways_in_use};
    assign ways_clamp = (ways_raw == 5'd0) ? 5'd1
                      : ((ways_raw > 5'(sacl_pkg::MAX_WAYS)) ? 5'(sacl_pkg::MAX_WAYS)
                                                             : ways_raw);

    assign req.ready = (state_reg == ST_IDLE);

    // Sequencer.
    assign last_way = ((sacl_pkg::WCNT_W'(scan_way_reg) + 1'b1) == ways_reg);
    assign commit   = (state_reg == ST_UPDATE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (last_way)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Access context and way counters.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            store_reg <= req.command;
            tag_reg   <= tag_calc;
            set_reg   <= set_calc;
            ways_reg  <= sacl_pkg::WCNT_W'(ways_clamp);
        end
        if (state_reg == ST_LOOKUP)
        begin
            rd_way_reg   <= sacl_pkg::WAY_W'(1);
            scan_way_reg <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            rd_way_reg   <= rd_way_reg + 1'b1;
            scan_way_reg <= scan_way_reg + 1'b1;
        end
    end

    // Tag memory: one read and one write port, registered read.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOKUP)
        begin
            tag_q <= tag_mem[{set_reg, {sacl_pkg::WAY_W{1'b0}}}];
        end
        else if (state_reg == ST_SCAN)
        begin
            tag_q <= tag_mem[{set_reg, rd_way_reg}];
        end
        if (commit && !scan.hit)
        begin
            tag_mem[{set_reg, w}] <= tag_reg;
        end
    end

    // Metadata memory, one row per set.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOKUP)
        begin
            meta_q <= meta_mem[set_reg];
        end
        if (commit)
        begin
            meta_mem[set_reg] <= meta_new;
        end
    end

    // Row-written flags; an unwritten row reads as all clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_init_reg <= '0;
            init_q       <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_LOOKUP)
            begin
                init_q <= row_init_reg[set_reg];
            end
            if (commit)
            begin
                row_init_reg[set_reg] <= 1'b1;
            end
        end
    end

    assign meta = init_q ? meta_q : '0;

    // Feed one way per cycle to the scanner.
    always_comb
    begin
        step.en    = (state_reg == ST_SCAN);
        step.first = (scan_way_reg == '0);
        step.way   = scan_way_reg;
        step.valid = meta.valid[scan_way_reg];
        step.rank  = meta.rank[scan_way_reg];
    end

    sacl_way_scan u_scan (
        .clk      (clk),
        .step     (step),
        .line_tag (tag_q),
        .ref_tag  (tag_reg),
        .res      (scan)
    );

    // Pick the way and build the new metadata row.
    assign w         = scan.hit ? scan.hit_way : (scan.empty ? scan.empty_way : scan.vict_way);
    assign old_dirty = meta.dirty[w];
    assign new_dirty = scan.hit ? (old_dirty || store_reg) : store_reg;
    assign limit     = scan.hit ? {1'b0, meta.rank[w]} : 4'd8;
    assign is_evict  = !scan.hit && !scan.empty;

    always_comb
    begin
        meta_new = meta;
        for (int i = 0; i < sacl_pkg::MAX_WAYS; i++)
        begin
            if ((sacl_pkg::WCNT_W'(i) < ways_reg) && (sacl_pkg::WAY_W'(i) != w)
                && meta.valid[i] && ({1'b0, meta.rank[i]} < limit)
                && (meta.rank[i] != sacl_pkg::RANK_MAX))
            begin
                meta_new.rank[i] = meta.rank[i] + 1'b1;
            end
        end
        meta_new.rank[w]  = '0;
        meta_new.valid[w] = 1'b1;
        meta_new.dirty[w] = new_dirty;
    end

    // Statistics.
    always_comb
    begin
        evt.commit      = commit;
        evt.hit         = scan.hit;
        evt.evict       = is_evict;
        evt.dirty_evict = is_evict && old_dirty;
        evt.dirty_inc   = new_dirty && !old_dirty;
        evt.dirty_dec   = old_dirty && !new_dirty;
    end

    sacl_stats u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt),
        .stats_next (stats_next)
    );

    // Result word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            outcome_reg   <= scan.hit ? sacl_pkg::OUT_HIT
                           : (scan.empty ? sacl_pkg::OUT_FILL : sacl_pkg::OUT_EVICT);
            vdirty_reg    <= is_evict && old_dirty;
            stats_out_reg <= stats_next;
        end
    end

    assign rsp.valid               = out_valid_reg;
    assign rsp.outcome             = outcome_reg;
    assign rsp.victim_was_dirty    = vdirty_reg;
    assign rsp.hit_total           = stats_out_reg.hits;
    assign rsp.miss_total          = stats_out_reg.misses;
    assign rsp.eviction_total      = stats_out_reg.evictions;
    assign rsp.dirty_resident      = stats_out_reg.dirty_res;
    assign rsp.dirty_evicted_total = stats_out_reg.dirty_evicts;

endmodule
